[rtl/core/aes_pkg.sv]
// AES-128 shared types, S-box tables and GF(2^8) helpers.
// No dependencies.
`timescale 1ns / 1ps
package aes_pkg;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        mode;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_word;

    localparam int RK_WORDS = 44;
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXPAND, ST_PRIME, ST_ROUND, ST_DONE
    } t_state;

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = t[x];
    endfunction

endpackage

[rtl/core/aes_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[rtl/core/aes_round.sv]
// One AES round datapath (encrypt or decrypt), combinational.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_round (
    input  logic [127:0] i_state,
    input  logic [127:0] i_rkey,
    input  logic         i_mode,
    input  logic         i_last,
    output logic [127:0] o_state
);
    logic [7:0] s [16];
    logic [7:0] sr [16];
    logic [7:0] sb [16];
    logic [7:0] ak [16];
    logic [7:0] mc [16];
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] x0, x1, x2, x3;
    logic [7:0] y0, y1, y2, y3;
    logic [7:0] z0, z1, z2, z3;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_state[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_mode == aes_pkg::MODE_DEC) begin
                    sr[4*((c+r)%4)+r] = s[4*c+r];
                end else begin
                    sr[4*c+r] = s[4*((c+r)%4)+r];
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            sb[i] = (i_mode == aes_pkg::MODE_DEC) ? aes_pkg::inv_sbox(sr[i])
                                                  : aes_pkg::sbox(sr[i]);
            // decrypt adds key before inverse mix, encrypt after mix
            ak[i] = (i_mode == aes_pkg::MODE_DEC) ? sb[i] ^ i_rkey[127-8*i -: 8] : sb[i];
        end
        for (int c = 0; c < 4; c++) begin
            a0 = ak[4*c]; a1 = ak[4*c+1]; a2 = ak[4*c+2]; a3 = ak[4*c+3];
            x0 = aes_pkg::xt(a0); x1 = aes_pkg::xt(a1);
            x2 = aes_pkg::xt(a2); x3 = aes_pkg::xt(a3);
            y0 = aes_pkg::xt(x0); y1 = aes_pkg::xt(x1);
            y2 = aes_pkg::xt(x2); y3 = aes_pkg::xt(x3);
            z0 = aes_pkg::xt(y0); z1 = aes_pkg::xt(y1);
            z2 = aes_pkg::xt(y2); z3 = aes_pkg::xt(y3);
            if (i_mode == aes_pkg::MODE_DEC) begin
                // 0e=8^4^2, 0b=8^2^1, 0d=8^4^1, 09=8^1
                mc[4*c]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
                mc[4*c+1] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
                mc[4*c+2] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
                mc[4*c+3] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
            end else begin
                mc[4*c]   = x0 ^ (x1^a1) ^ a2 ^ a3;
                mc[4*c+1] = a0 ^ x1 ^ (x2^a2) ^ a3;
                mc[4*c+2] = a0 ^ a1 ^ x2 ^ (x3^a3);
                mc[4*c+3] = (x0^a0) ^ a1 ^ a2 ^ x3;
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (i_mode == aes_pkg::MODE_DEC) begin
                o_state[127-8*i -: 8] = i_last ? ak[i] : mc[i];
            end else begin
                o_state[127-8*i -: 8] = (i_last ? sb[i] : mc[i]) ^ i_rkey[127-8*i -: 8];
            end
        end
    end
endmodule

[rtl/core/aes_keyexp.sv]
// Round-key expansion step: next 128-bit round key from the previous one.
// Depends on aes_pkg.
`timescale 1ns / 1ps
module aes_keyexp (
    input  logic [127:0] i_key,
    input  logic [7:0]   i_rcon,
    output logic [127:0] o_key
);
    logic [31:0] w3, t, k0, k1, k2, k3;
    always_comb begin
        w3 = i_key[31:0];
        t  = {aes_pkg::sbox(w3[23:16]), aes_pkg::sbox(w3[15:8]),
              aes_pkg::sbox(w3[7:0]),   aes_pkg::sbox(w3[31:24])} ^ {i_rcon, 24'h0};
        k0 = i_key[127:96] ^ t;
        k1 = i_key[95:64] ^ k0;
        k2 = i_key[63:32] ^ k1;
        k3 = i_key[31:0] ^ k2;
        o_key = {k0, k1, k2, k3};
    end
endmodule

[rtl/core/aes128_block_cipher.sv]
// AES-128 encrypt/decrypt core with key schedule held in a round-key RAM.
// Sequence from accepted word to valid result: expand states writing round
//   keys 0..10, a prime state issuing the first key read, and round states
//   for the initial key add plus ten rounds.
// Flow: one block at a time; input is held off from acceptance until the
//   result word is taken, after which the return to idle reopens the input.
// Reset: i_rst_n synchronous active low clears control and key registers.
// Depends on aes_pkg, aes_ram, aes_round, aes_keyexp.
`timescale 1ns / 1ps
module aes128_block_cipher (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  aes_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output aes_pkg::t_out_word  o_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [63:0]         i_cfg_data
);
    aes_pkg::t_state r_st, n_st;
    logic [63:0]  r_key_hi, r_key_lo;
    logic [127:0] r_rk, n_rk;       // key being expanded
    logic [7:0]   r_rcon, n_rcon;
    logic [3:0]   r_cnt, n_cnt;     // round/key index 0..10
    logic [127:0] r_blk, n_blk;
    logic         r_mode, n_mode;
    logic         r_oval, n_oval;
    logic [127:0] next_key, round_out, ram_rd;
    logic         ram_we;
    logic [3:0]   ram_wa, ram_ra;
    logic [7:0]   rcon_next;

    // Round-key store: 11 rows of 128 bits (44 words), written during expansion.
    aes_ram #(.WIDTH(128), .DEPTH(11)) u_rk_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(r_rk),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    aes_keyexp u_kx (.i_key(r_rk), .i_rcon(r_rcon), .o_key(next_key));

    aes_round u_rnd (
        .i_state(r_blk), .i_rkey(ram_rd), .i_mode(r_mode),
        .i_last(r_cnt == 4'd10), .o_state(round_out)
    );

    assign rcon_next = aes_pkg::xt(r_rcon);
    assign o_ready   = (r_st == aes_pkg::ST_IDLE);
    assign o_valid   = r_oval;
    assign o_data    = {r_blk[127:64], r_blk[63:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= aes_pkg::ST_IDLE;
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_oval <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            r_oval <= n_oval;
            r_cnt <= n_cnt;
            if (i_cfg_we && i_cfg_index == aes_pkg::CFG_KEY_HIGH) r_key_hi <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == aes_pkg::CFG_KEY_LOW)  r_key_lo <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rk <= n_rk;
        r_rcon <= n_rcon;
        r_blk <= n_blk;
        r_mode <= n_mode;
    end

    always_comb begin
        n_st = r_st; n_rk = r_rk; n_rcon = r_rcon; n_cnt = r_cnt;
        n_blk = r_blk; n_mode = r_mode; n_oval = r_oval;
        ram_we = 1'b0; ram_wa = r_cnt; ram_ra = r_cnt;
        unique case (r_st)
            aes_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_blk = {i_data.block_high, i_data.block_low};
                    n_mode = i_data.mode;
                    n_rk = {r_key_hi, r_key_lo};
                    n_rcon = 8'h01;
                    n_cnt = '0;
                    n_st = aes_pkg::ST_EXPAND;
                end
            end
            aes_pkg::ST_EXPAND: begin
                // write round key r_cnt, step schedule
                ram_we = 1'b1;
                n_rk = next_key;
                n_rcon = rcon_next;
                if (r_cnt == 4'd10) begin
                    n_cnt = (r_mode == aes_pkg::MODE_DEC) ? 4'd10 : 4'd0;
                    n_st = aes_pkg::ST_PRIME;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            aes_pkg::ST_PRIME: begin
                // issue the first key read (key 0 enc, key 10 dec); ROUND reads the following keys
                n_cnt = 4'd1;
                ram_ra = (r_mode == aes_pkg::MODE_DEC) ? 4'd10 : 4'd0;
                n_st = aes_pkg::ST_ROUND;
                n_blk = r_blk;
                // initial add happens next cycle via r_cnt==0 trick below
                n_cnt = 4'd0;
            end
            aes_pkg::ST_ROUND: begin
                // r_cnt = rounds done; ram_rd holds key for this step
                ram_ra = (r_mode == aes_pkg::MODE_DEC) ? 4'd9 - r_cnt : r_cnt + 4'd1;
                if (r_cnt == 4'd0) begin
                    n_blk = r_blk ^ ram_rd;
                end else begin
                    n_blk = round_out;
                end
                if (r_cnt == 4'd10) begin
                    n_oval = 1'b1;
                    n_st = aes_pkg::ST_DONE;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            aes_pkg::ST_DONE: begin
                if (i_ready) begin
                    n_oval = 1'b0;
                    n_st = aes_pkg::ST_IDLE;
                end
            end
            default: n_st = aes_pkg::ST_IDLE;
        endcase
    end

    // Round key index used by the round logic: ram_rd was addressed in the previous cycle.
    // In ST_ROUND with r_cnt==k, key index is k (enc) or 10-k (dec).

`ifndef SYNTHESIS
    a_out_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_st == aes_pkg::ST_DONE) else $error("valid outside done");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_data)) else $error("result changed");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while busy");
`endif
endmodule
